>>> src/rgbablend_pkg.sv
// Shared constants, types and helpers for the RGBA-over-NV12 pixel blender.
package rgbablend_pkg;

   localparam int DIM_W = 13;
   localparam logic [DIM_W-1:0] FRAME_DIM_MAX = 13'd4096;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1920;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1080;

   localparam int LUMA_ADDR_W   = 24;
   localparam int CHROMA_ADDR_W = 25;

   // Register indexes on the csr channel
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_CHROMA_ORDER = 2'd2;

   // BT.601 coefficients, Q16
   localparam logic [15:0] K_YR = 16'd19595;
   localparam logic [15:0] K_YG = 16'd38470;
   localparam logic [15:0] K_YB = 16'd7471;
   localparam logic [15:0] K_UR = 16'd11076;
   localparam logic [15:0] K_UG = 16'd21692;
   localparam logic [15:0] K_VG = 16'd27460;
   localparam logic [15:0] K_VB = 16'd5308;
   localparam logic [24:0] UV_OFFSET = 25'd8388608;

   // Load enables of the two conversion stages
   typedef struct packed {
      logic s1_load;
      logic s2_load;
   } csc_ctl_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
   } yuv_type;

   // Exact floor(n / 255) for n <= 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] n);
      logic [16:0] t;
      t = {1'b0, n} + {9'd0, n[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

>>> src/rgbablend_csc.sv
// Two-stage RGB to BT.601 YUV converter with Q16 constant coefficients.
module rgbablend_csc (
   input  logic                      clock,
   input  rgbablend_pkg::csc_ctl_type ctl,
   input  logic [7:0]                red,
   input  logic [7:0]                green,
   input  logic [7:0]                blue,
   output rgbablend_pkg::yuv_type    yuv
);

   logic [23:0] yr_ff, yg_ff, yb_ff;
   logic [23:0] ur_ff, ug_ff, vg_ff, vb_ff;
   logic [7:0]  red_ff, blue_ff;
   logic [24:0] y_sum, u_sum, v_sum;
   rgbablend_pkg::yuv_type yuv_ff;

   always_ff @(posedge clock) begin
      if (ctl.s1_load) begin
         yr_ff   <= 24'(red)   * 24'(rgbablend_pkg::K_YR);
         yg_ff   <= 24'(green) * 24'(rgbablend_pkg::K_YG);
         yb_ff   <= 24'(blue)  * 24'(rgbablend_pkg::K_YB);
         ur_ff   <= 24'(red)   * 24'(rgbablend_pkg::K_UR);
         ug_ff   <= 24'(green) * 24'(rgbablend_pkg::K_UG);
         vg_ff   <= 24'(green) * 24'(rgbablend_pkg::K_VG);
         vb_ff   <= 24'(blue)  * 24'(rgbablend_pkg::K_VB);
         red_ff  <= red;
         blue_ff <= blue;
      end
   end

   // Sums never go negative and stay below 2^24, so bits 23:16 are the result
   always_comb begin
      y_sum = {1'b0, yr_ff} + {1'b0, yg_ff} + {1'b0, yb_ff};
      u_sum = {2'b0, blue_ff, 15'd0} + rgbablend_pkg::UV_OFFSET
              - {1'b0, ur_ff} - {1'b0, ug_ff};
      v_sum = {2'b0, red_ff, 15'd0} + rgbablend_pkg::UV_OFFSET
              - {1'b0, vg_ff} - {1'b0, vb_ff};
   end

   always_ff @(posedge clock) begin
      if (ctl.s2_load) begin
         yuv_ff.luma <= y_sum[23:16];
         yuv_ff.cb   <= u_sum[23:16];
         yuv_ff.cr   <= v_sum[23:16];
      end
   end

   assign yuv = yuv_ff;

endmodule

>>> src/rgba_over_nv12_pixel_blend_unit.sv
// Top level: RGBA over NV12/NV21 pixel blender, four-stage pipeline.
//
//   channel | direction | payload
//   --------+-----------+------------------------------------------------------
//   req_    | in        | tdata: position, RGBA, old luma and chroma pair
//   rsp_    | out       | tdata: blended bytes and addresses; tuser: write flags
//   csr_    | in        | csr_index/csr_data register write, always ready
//
// One transaction per cycle is sustained while rsp_tready stays high. Stages:
// color products and frame test; YUV sums, chroma row product and luma address;
// blend products and chroma address; divide by 255 into rsp. Each stage takes new
// data when empty or when the next one moves, so bubbles close up under a stall.
// Reset is synchronous and clears valid bits and config.
module rgba_over_nv12_pixel_blend_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pos_x[12:0] pos_y[25:13] src_red[33:26] src_green[41:34] src_blue[49:42]
   // src_alpha[57:50] old_luma[65:58] old_chroma_first[73:66]
   // old_chroma_second[81:74], zero fill to 88
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_luma[7:0] luma_address[31:8] new_chroma_first[39:32]
   // new_chroma_second[47:40] chroma_address[72:48], zero fill to 80
   output logic [79:0] rsp_tdata,
   // luma_write[0] chroma_write[1]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   localparam int DW = rgbablend_pkg::DIM_W;

   // configuration
   logic [DW-1:0] width_ff, height_ff;
   logic          order_ff;
   logic [DW-1:0] w_sat, h_sat;
   logic [rgbablend_pkg::CHROMA_ADDR_W-1:0] wh_ff;
   logic [25:0]   wh_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rgbablend_pkg::WIDTH_RESET;
         height_ff <= rgbablend_pkg::HEIGHT_RESET;
         order_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            rgbablend_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_data;
            rgbablend_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_data;
            rgbablend_pkg::CSR_CHROMA_ORDER: order_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_sat = (width_ff > rgbablend_pkg::FRAME_DIM_MAX) ? rgbablend_pkg::FRAME_DIM_MAX
                                                        : width_ff;
      h_sat = (height_ff > rgbablend_pkg::FRAME_DIM_MAX) ? rgbablend_pkg::FRAME_DIM_MAX
                                                         : height_ff;
      wh_in = 26'(w_sat) * 26'(h_sat);
   end

   // frame size product is only needed from stage 3 on
   always_ff @(posedge clock) begin
      wh_ff <= wh_in[rgbablend_pkg::CHROMA_ADDR_W-1:0];
   end

   // stage control
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic ld1, ld2, ld3, ld4;

   assign ld4 = !v4_ff || rsp_tready;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign req_tready = ld1;

   always_comb begin
      v1_in = ld1 ? req_tvalid : v1_ff;
      v2_in = ld2 ? v1_ff : v2_ff;
      v3_in = ld3 ? v2_ff : v3_ff;
      v4_in = ld4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // input unpack
   logic [12:0] in_x, in_y;
   logic [7:0]  in_red, in_green, in_blue, in_alpha, in_luma, in_c0, in_c1;
   logic        in_frame;
   logic [24:0] luma_prod;

   always_comb begin
      in_x     = req_tdata[12:0];
      in_y     = req_tdata[25:13];
      in_red   = req_tdata[33:26];
      in_green = req_tdata[41:34];
      in_blue  = req_tdata[49:42];
      in_alpha = req_tdata[57:50];
      in_luma  = req_tdata[65:58];
      in_c0    = req_tdata[73:66];
      in_c1    = req_tdata[81:74];
      // negative coordinates fail on the sign bit; inside, 12 bits suffice
      in_frame = !in_x[12] && !in_y[12]
                 && ({1'b0, in_x[11:0]} < w_sat) && ({1'b0, in_y[11:0]} < h_sat)
                 && (in_alpha != 8'd0);
      luma_prod = 25'(in_y[11:0]) * 25'(w_sat);
   end

   // color conversion runs alongside stages 1 and 2
   rgbablend_pkg::csc_ctl_type csc_ctl;
   rgbablend_pkg::yuv_type     yuv;

   assign csc_ctl.s1_load = ld1;
   assign csc_ctl.s2_load = ld2;

   rgbablend_csc u_csc (
      .clock (clock),
      .ctl   (csc_ctl),
      .red   (in_red),
      .green (in_green),
      .blue  (in_blue),
      .yuv   (yuv)
   );

   // stage 1
   logic        s1_lw_ff, s1_cw_ff;
   logic [7:0]  s1_alpha_ff, s1_luma_ff, s1_c0_ff, s1_c1_ff;
   logic [10:0] s1_xh_ff, s1_yh_ff;
   logic        s1_x0_ff;
   logic [rgbablend_pkg::LUMA_ADDR_W-1:0] s1_laddr_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_lw_ff    <= in_frame;
         s1_cw_ff    <= in_frame && !in_x[0] && !in_y[0];
         s1_alpha_ff <= in_alpha;
         s1_luma_ff  <= in_luma;
         s1_c0_ff    <= in_c0;
         s1_c1_ff    <= in_c1;
         s1_xh_ff    <= in_x[11:1];
         s1_x0_ff    <= in_x[0];
         s1_yh_ff    <= in_y[11:1];
         s1_laddr_ff <= luma_prod[rgbablend_pkg::LUMA_ADDR_W-1:0];
      end
   end

   // stage 2
   logic        s2_lw_ff, s2_cw_ff;
   logic [7:0]  s2_alpha_ff, s2_luma_ff, s2_c0_ff, s2_c1_ff;
   logic [10:0] s2_xh_ff;
   logic [rgbablend_pkg::LUMA_ADDR_W-1:0] s2_laddr_ff;
   logic [23:0] s2_crow_ff;
   logic [23:0] crow_in;

   assign crow_in = 24'(s1_yh_ff) * 24'(w_sat);

   always_ff @(posedge clock) begin
      if (ld2) begin
         s2_lw_ff    <= s1_lw_ff;
         s2_cw_ff    <= s1_cw_ff;
         s2_alpha_ff <= s1_alpha_ff;
         s2_luma_ff  <= s1_luma_ff;
         s2_c0_ff    <= s1_c0_ff;
         s2_c1_ff    <= s1_c1_ff;
         s2_xh_ff    <= s1_xh_ff;
         s2_laddr_ff <= s1_laddr_ff
                        + rgbablend_pkg::LUMA_ADDR_W'({s1_xh_ff, s1_x0_ff});
         s2_crow_ff  <= crow_in;
      end
   end

   // stage 3: blend numerators and chroma address
   logic [7:0]  inv_alpha, new_c0, new_c1;
   logic [15:0] ly_in, c0_in, c1_in;
   logic [rgbablend_pkg::CHROMA_ADDR_W-1:0] caddr_in;
   logic        s3_lw_ff, s3_cw_ff;
   logic [15:0] s3_ly_ff, s3_c0_ff, s3_c1_ff;
   logic [rgbablend_pkg::LUMA_ADDR_W-1:0]   s3_laddr_ff;
   logic [rgbablend_pkg::CHROMA_ADDR_W-1:0] s3_caddr_ff;

   always_comb begin
      inv_alpha = ~s2_alpha_ff;  // 255 - alpha
      new_c0 = order_ff ? yuv.cr : yuv.cb;
      new_c1 = order_ff ? yuv.cb : yuv.cr;
      // each sum is at most 255 * 255
      ly_in = 16'(s2_luma_ff) * 16'(inv_alpha) + 16'(yuv.luma) * 16'(s2_alpha_ff);
      c0_in = 16'(s2_c0_ff) * 16'(inv_alpha) + 16'(new_c0) * 16'(s2_alpha_ff);
      c1_in = 16'(s2_c1_ff) * 16'(inv_alpha) + 16'(new_c1) * 16'(s2_alpha_ff);
      caddr_in = wh_ff + {1'b0, s2_crow_ff}
                 + rgbablend_pkg::CHROMA_ADDR_W'({s2_xh_ff, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         s3_lw_ff    <= s2_lw_ff;
         s3_cw_ff    <= s2_cw_ff;
         s3_ly_ff    <= ly_in;
         s3_c0_ff    <= c0_in;
         s3_c1_ff    <= c1_in;
         s3_laddr_ff <= s2_laddr_ff;
         s3_caddr_ff <= caddr_in;
      end
   end

   // stage 4: divide by 255, zero the fields that are not written
   logic [7:0]  rsp_luma_ff, rsp_c0_ff, rsp_c1_ff;
   logic [rgbablend_pkg::LUMA_ADDR_W-1:0]   rsp_laddr_ff;
   logic [rgbablend_pkg::CHROMA_ADDR_W-1:0] rsp_caddr_ff;
   logic        rsp_lw_ff, rsp_cw_ff;

   always_ff @(posedge clock) begin
      if (ld4) begin
         rsp_lw_ff    <= s3_lw_ff;
         rsp_cw_ff    <= s3_cw_ff;
         rsp_luma_ff  <= s3_lw_ff ? rgbablend_pkg::div255(s3_ly_ff) : 8'd0;
         rsp_laddr_ff <= s3_lw_ff ? s3_laddr_ff : '0;
         rsp_c0_ff    <= s3_cw_ff ? rgbablend_pkg::div255(s3_c0_ff) : 8'd0;
         rsp_c1_ff    <= s3_cw_ff ? rgbablend_pkg::div255(s3_c1_ff) : 8'd0;
         rsp_caddr_ff <= s3_cw_ff ? s3_caddr_ff : '0;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tuser  = {rsp_cw_ff, rsp_lw_ff};
   assign rsp_tdata  = {7'd0, rsp_caddr_ff, rsp_c1_ff, rsp_c0_ff, rsp_laddr_ff,
                        rsp_luma_ff};

endmodule

>>> src/rgbablend_checker.sv
// Port-level checker for the pixel blender, bound to the top level.
module rgbablend_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // chroma is only written together with luma
   a_chroma_needs_luma: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("chroma_write without luma_write");

   // no luma write: every field is zero
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 80'd0)
      else $error("nonzero data without luma_write");

   // luma only: chroma fields are zero
   a_luma_only_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && !rsp_tuser[1] |-> rsp_tdata[72:32] == 41'd0)
      else $error("nonzero chroma fields without chroma_write");

endmodule

bind rgba_over_nv12_pixel_blend_unit rgbablend_checker u_rgbablend_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/tb_rgba_over_nv12_pixel_blend_unit.sv
// Self-checking testbench for the RGBA-over-NV12/NV21 pixel blender top level.
`timescale 1ns / 100ps

module tb_rgba_over_nv12_pixel_blend_unit;

   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;  // not mapped, writes must be dropped
   localparam int DIRECTED_ROWS  = 17;
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 57;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic signed [12:0] pos_x;
      logic signed [12:0] pos_y;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic [7:0]         old_luma;
      logic [7:0]         old_chroma_first;
      logic [7:0]         old_chroma_second;
   } pixel_type;

   typedef struct packed {
      logic        luma_write;
      logic [7:0]  new_luma;
      logic [23:0] luma_address;
      logic        chroma_write;
      logic [7:0]  new_chroma_first;
      logic [7:0]  new_chroma_second;
      logic [24:0] chroma_address;
   } pixel_write_type;

   typedef struct packed {
      pixel_type       px;
      logic            typed;
      pixel_write_type want;
   } stim_row_type;

   localparam pixel_write_type NO_WRITE = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = rgbablend_pkg::CSR_FRAME_WIDTH;
   logic [12:0] csr_data = '0;

   // shadow of the frame setup registers
   logic [12:0] cfg_width  = rgbablend_pkg::WIDTH_RESET;
   logic [12:0] cfg_height = rgbablend_pkg::HEIGHT_RESET;
   logic        cfg_order  = 1'b0;

   pixel_write_type pending_writes[$];
   stim_row_type    directed_rows[DIRECTED_ROWS];
   int              mismatch_count = 0;
   int              write_count = 0;
   int              quiet_cycles = 0;
   int              stall_left = 0;
   bit              calm = 1'b0;

   rgba_over_nv12_pixel_blend_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   function automatic int eff_dim(input logic [12:0] d);
      return (d > rgbablend_pkg::FRAME_DIM_MAX) ? int'(rgbablend_pkg::FRAME_DIM_MAX)
                                                : int'(d);
   endfunction

   function automatic logic [7:0] mix255(input int old_v, input int fresh_v, input int a);
      return 8'((old_v * (255 - a) + fresh_v * a) / 255);
   endfunction

   // BT.601 in Q16, then alpha blend per channel
   function automatic pixel_write_type predict_blend(input pixel_type p);
      int ew, eh, x, y, a, yv, uv, vv;
      pixel_write_type w;
      w  = NO_WRITE;
      ew = eff_dim(cfg_width);
      eh = eff_dim(cfg_height);
      x  = int'($signed(p.pos_x));
      y  = int'($signed(p.pos_y));
      a  = int'(p.alpha);
      if (x < 0 || y < 0 || x >= ew || y >= eh || a == 0) return w;
      yv = (19595 * p.red + 38470 * p.green + 7471 * p.blue) >> 16;
      uv = (32768 * p.blue + 8388608 - 11076 * p.red - 21692 * p.green) >> 16;
      vv = (32768 * p.red + 8388608 - 27460 * p.green - 5308 * p.blue) >> 16;
      w.luma_write   = 1'b1;
      w.new_luma     = mix255(p.old_luma, yv, a);
      w.luma_address = 24'(y * ew + x);
      if ((x % 2) == 0 && (y % 2) == 0) begin
         w.chroma_write      = 1'b1;
         w.new_chroma_first  = mix255(p.old_chroma_first, cfg_order ? vv : uv, a);
         w.new_chroma_second = mix255(p.old_chroma_second, cfg_order ? uv : vv, a);
         w.chroma_address    = 25'(ew * eh + (y / 2) * ew + (x / 2) * 2);
      end
      return w;
   endfunction

   function automatic pixel_type pix(input int x, input int y, input int r, input int g,
                                     input int b, input int a, input int ol, input int oc0,
                                     input int oc1);
      pixel_type p;
      p.pos_x = 13'(x);
      p.pos_y = 13'(y);
      p.red = 8'(r);
      p.green = 8'(g);
      p.blue = 8'(b);
      p.alpha = 8'(a);
      p.old_luma = 8'(ol);
      p.old_chroma_first = 8'(oc0);
      p.old_chroma_second = 8'(oc1);
      return p;
   endfunction

   function automatic pixel_write_type wr(input int lw, input int nl, input int la,
                                          input int cw, input int c0, input int c1,
                                          input int ca);
      pixel_write_type w;
      w.luma_write = 1'(lw);
      w.new_luma = 8'(nl);
      w.luma_address = 24'(la);
      w.chroma_write = 1'(cw);
      w.new_chroma_first = 8'(c0);
      w.new_chroma_second = 8'(c1);
      w.chroma_address = 25'(ca);
      return w;
   endfunction

   function automatic int pick_gap();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   function automatic int near_border(input int d);
      case ($urandom_range(0, 4))
         0: return -1;
         1: return 0;
         2: return d - 1;
         3: return d;
         default: return d + 1;
      endcase
   endfunction

   // mostly pixels inside the frame, the rest on its border or anywhere
   function automatic pixel_type random_pixel();
      int ew, eh, x, y, sel;
      pixel_type p;
      ew  = eff_dim(cfg_width);
      eh  = eff_dim(cfg_height);
      sel = $urandom_range(0, 99);
      if (sel < 65 && ew > 0 && eh > 0) begin
         x = $urandom_range(0, ew - 1);
         y = $urandom_range(0, eh - 1);
         if ($urandom_range(0, 1) == 1) begin
            x = x & ~1;
            y = y & ~1;
         end
      end else if (sel < 80) begin
         x = near_border(ew);
         y = near_border(eh);
      end else begin
         x = $urandom_range(0, 8191);
         y = $urandom_range(0, 8191);
      end
      p = pix(x, y, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      sel = $urandom_range(0, 99);
      if (sel < 15) p.alpha = 8'd0;
      else if (sel < 30) p.alpha = 8'd255;
      return p;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (got_v !== want_v)
         flag_mismatch($sformatf("write %0d %s: expected 0x%0h, got 0x%0h",
                                 write_count, name, want_v, got_v));
   endtask

   // csr_valid is left high; the caller drops it after the last write
   task automatic write_csr(input logic [1:0] idx, input logic [12:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rgbablend_pkg::CSR_FRAME_WIDTH:  cfg_width = data;
         rgbablend_pkg::CSR_FRAME_HEIGHT: cfg_height = data;
         rgbablend_pkg::CSR_CHROMA_ORDER: cfg_order = data[0];
         default: ;
      endcase
   endtask

   task automatic push_pixel(input pixel_type px, input logic typed,
                             input pixel_write_type want);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, px.old_chroma_second, px.old_chroma_first, px.old_luma,
                     px.alpha, px.blue, px.green, px.red, px.pos_y, px.pos_x};
      do @(posedge clock); while (!req_tready);
      pending_writes.push_back(typed ? want : predict_blend(px));
   endtask

   // optional sender gap; drop forces tvalid low at the end of a block
   task automatic sender_gap(input bit drop);
      int gap;
      gap = (!calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
      if (gap != 0 || drop) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (pending_writes.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 99) < 15) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      pixel_write_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.luma_write        = rsp_tuser[0];
         got.chroma_write      = rsp_tuser[1];
         got.new_luma          = rsp_tdata[7:0];
         got.luma_address      = rsp_tdata[31:8];
         got.new_chroma_first  = rsp_tdata[39:32];
         got.new_chroma_second = rsp_tdata[47:40];
         got.chroma_address    = rsp_tdata[72:48];
         if (pending_writes.size() == 0) begin
            flag_mismatch($sformatf("write %0d arrived with nothing outstanding", write_count));
         end else begin
            want = pending_writes.pop_front();
            compare_field("luma_write", want.luma_write, got.luma_write);
            compare_field("new_luma", want.new_luma, got.new_luma);
            compare_field("luma_address", want.luma_address, got.luma_address);
            compare_field("chroma_write", want.chroma_write, got.chroma_write);
            compare_field("new_chroma_first", want.new_chroma_first, got.new_chroma_first);
            compare_field("new_chroma_second", want.new_chroma_second,
                          got.new_chroma_second);
            compare_field("chroma_address", want.chroma_address, got.chroma_address);
         end
         write_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int ph, k, w, h;
      bit order;

      // reset setup is 1920x1080, U then V
      directed_rows[0]  = '{pix(0, 0, 255, 255, 255, 255, 0, 0, 0), 1'b1,
                            wr(1, 255, 0, 1, 128, 128, 2073600)};
      directed_rows[1]  = '{pix(0, 0, 0, 0, 0, 255, 255, 255, 255), 1'b1,
                            wr(1, 0, 0, 1, 128, 128, 2073600)};
      directed_rows[2]  = '{pix(0, 0, 255, 255, 255, 0, 17, 17, 17), 1'b1, NO_WRITE};
      directed_rows[3]  = '{pix(-1, 0, 255, 255, 255, 255, 0, 0, 0), 1'b1, NO_WRITE};
      directed_rows[4]  = '{pix(0, -1, 255, 255, 255, 255, 0, 0, 0), 1'b1, NO_WRITE};
      directed_rows[5]  = '{pix(1920, 0, 255, 255, 255, 255, 0, 0, 0), 1'b1, NO_WRITE};
      directed_rows[6]  = '{pix(0, 1080, 255, 255, 255, 255, 0, 0, 0), 1'b1, NO_WRITE};
      directed_rows[7]  = '{pix(1919, 1079, 255, 255, 255, 255, 0, 0, 0), 1'b1,
                            wr(1, 255, 2073599, 0, 0, 0, 0)};
      directed_rows[8]  = '{pix(-4096, -4096, 255, 255, 255, 255, 0, 0, 0), 1'b1, NO_WRITE};
      directed_rows[9]  = '{pix(4095, 4095, 255, 255, 255, 255, 0, 0, 0), 1'b1, NO_WRITE};
      directed_rows[10] = '{pix(1, 0, 255, 0, 0, 255, 90, 12, 240), 1'b0, NO_WRITE};
      directed_rows[11] = '{pix(0, 1, 0, 255, 0, 128, 200, 3, 77), 1'b0, NO_WRITE};
      directed_rows[12] = '{pix(2, 2, 0, 0, 255, 1, 255, 255, 0), 1'b0, NO_WRITE};
      directed_rows[13] = '{pix(1918, 1078, 37, 190, 64, 254, 255, 0, 255), 1'b0, NO_WRITE};
      directed_rows[14] = '{pix(100, 50, 255, 255, 0, 200, 0, 255, 128), 1'b0, NO_WRITE};
      directed_rows[15] = '{pix(7, 3, 128, 128, 128, 255, 1, 2, 3), 1'b0, NO_WRITE};
      directed_rows[16] = '{pix(0, 0, 255, 255, 255, 255, 255, 255, 255), 1'b1,
                            wr(1, 255, 0, 1, 128, 128, 2073600)};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIRECTED_ROWS; k++) begin
         push_pixel(directed_rows[k].px, directed_rows[k].typed, directed_rows[k].want);
         sender_gap(k == DIRECTED_ROWS - 1);
      end

      for (ph = 0; ph < PHASES; ph++) begin
         // setup changes only with the pipeline empty
         wait_drained();
         case (ph)
            0: begin w = 4096; h = 4096; order = 1'b1; end
            1: begin w = 2;    h = 2;    order = 1'b0; end
            2: begin w = 8191; h = 5000; order = 1'b1; end  // both saturate
            3: begin w = 0;    h = 37;   order = 1'b0; end
            4: begin w = 33;   h = 0;    order = 1'b1; end
            5: begin w = 1023; h = 577;  order = 1'b1; end
            default: begin
               w = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 8191)
                                                : $urandom_range(2, 4096);
               h = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 8191)
                                                : $urandom_range(2, 4096);
               order = 1'($urandom_range(0, 1));
            end
         endcase
         calm = (ph % 4 == 1);
         write_csr(rgbablend_pkg::CSR_FRAME_WIDTH, 13'(w));
         write_csr(rgbablend_pkg::CSR_FRAME_HEIGHT, 13'(h));
         write_csr(rgbablend_pkg::CSR_CHROMA_ORDER, {12'($urandom), order});
         write_csr(CSR_SPARE_INDEX, 13'($urandom));
         csr_valid <= 1'b0;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            push_pixel(random_pixel(), 1'b0, NO_WRITE);
            sender_gap(k == PHASE_ITEMS - 1);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (pending_writes.size() != 0)
         flag_mismatch($sformatf("%0d pixel writes never arrived", pending_writes.size()));
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> rgba_over_nv12_pixel_blend_unit.f
src/rgbablend_pkg.sv
src/rgbablend_csc.sv
src/rgba_over_nv12_pixel_blend_unit.sv
src/rgbablend_checker.sv
tb/tb_rgba_over_nv12_pixel_blend_unit.sv
